// ===== design/assert_macros.svh =====
// assertion macros shared by the scaler modules
// no dependencies; assertions compile away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RRPS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rrps assertion failed");
`define RRPS_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("rrps assertion failed");
`else
`define RRPS_ASSERT(label, clk, rst_n, prop)
`define RRPS_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== design/rrps_pkg.sv =====
// types, sizes and helpers of the rounded-rect photo scaler
// used by every module of the block; no dependencies
package rrps_pkg;

    // store and dimension limits
    localparam int MAX_SOURCE_DIM = 256;
    localparam int MAX_KISS_DIM   = 2048;
    localparam int STORE_DEPTH    = MAX_SOURCE_DIM * MAX_SOURCE_DIM;
    localparam int ADDR_W         = $clog2(STORE_DEPTH);
    localparam int SDIM_W         = $clog2(MAX_SOURCE_DIM + 1);
    localparam int KDIM_W         = $clog2(MAX_KISS_DIM + 1);

    // field and register widths
    localparam int CFG_KISS_W  = 12;
    localparam int CFG_RAD_W   = 11;
    localparam int CFG_SRC_W   = 9;
    localparam int CFG_DATA_W  = 12;
    localparam int CFG_IDX_W   = 3;
    localparam int SRC_ADDR_W  = 16;
    localparam int COLOR_W     = 24;
    localparam int DEST_W      = 11;

    // derived arithmetic widths
    localparam int RAD_W   = CFG_RAD_W;
    localparam int SQ_W    = 2 * RAD_W;
    localparam int R2_W    = 2 * RAD_W;
    localparam int DRAW_W  = SDIM_W + KDIM_W;
    localparam int OFF_W   = DRAW_W + 1;
    localparam int POS_W   = OFF_W + 1;
    localparam int PROD_W  = POS_W - 1 + SDIM_W;
    localparam int RECIP_W = PROD_W + 1;
    localparam int DIV_W   = RECIP_W;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int DSR_W   = (KDIM_W > SDIM_W + 1) ? KDIM_W : SDIM_W + 1;
    localparam int REM_W   = DSR_W + 1;
    localparam int MASK_W  = ((KDIM_W > DEST_W) ? KDIM_W : DEST_W) + 2;
    localparam int PM_W    = KDIM_W + SDIM_W;
    localparam int MUL_W   = PROD_W + RECIP_W;
    localparam int NP_W    = PROD_W + DSR_W;
    localparam int IX_W    = 2 * SDIM_W;

    // command queue between front and back
    localparam int CQ_DEPTH  = 4;
    localparam int CQ_PTR_W  = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W  = $clog2(CQ_DEPTH + 1);

    // result queue and its credit count
    localparam int OUT_DEPTH = 16;
    localparam int OPTR_W    = $clog2(OUT_DEPTH);
    localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);
    localparam int CRED_W    = OCNT_W + 1;

    localparam logic [COLOR_W-1:0] WHITE = {3{8'hFF}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KISS_W  = 3'd0,
        REG_KISS_H  = 3'd1,
        REG_RADIUS  = 3'd2,
        REG_SRC_W   = 3'd3,
        REG_SRC_H   = 3'd4,
        REG_CROP    = 3'd5
    } t_reg_idx;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_RENDER = 1'b1
    } t_opcode;

    typedef struct packed {
        t_opcode                 opcode;
        logic [SRC_ADDR_W-1:0]   source_address;
        logic [COLOR_W-1:0]      source_color;
        logic [DEST_W-1:0]       dest_x;
        logic [DEST_W-1:0]       dest_y;
    } t_in_item;

    typedef struct packed {
        logic                written;
        logic                from_photo;
        logic [COLOR_W-1:0]  pixel_color;
    } t_out_item;

    // classified command handed from front to back
    typedef struct packed {
        logic                is_render;
        logic                ld_ok;
        logic [ADDR_W-1:0]   addr;
        logic [COLOR_W-1:0]  color;
        logic [DEST_W-1:0]   dest_x;
        logic [DEST_W-1:0]   dest_y;
    } t_cmd;

    // geometry computed once per configuration
    typedef struct packed {
        logic [KDIM_W-1:0]        kw;
        logic [KDIM_W-1:0]        kh;
        logic [SDIM_W-1:0]        sw;
        logic [SDIM_W-1:0]        sh;
        logic [RAD_W-1:0]         r;
        logic [R2_W-1:0]          r2;
        logic [DSR_W-1:0]         num;
        logic [SDIM_W-1:0]        den;
        logic [RECIP_W-1:0]       recip;
        logic [DRAW_W-1:0]        draw_w;
        logic [DRAW_W-1:0]        draw_h;
        logic signed [OFF_W-1:0]  off_x;
        logic signed [OFF_W-1:0]  off_y;
    } t_derived;

    function automatic logic [KDIM_W-1:0] clamp_kiss(input logic [CFG_KISS_W-1:0] v);
        logic [KDIM_W-1:0] res;
        if (v == '0) begin
            res = KDIM_W'(1);
        end else if (32'(v) > 32'(MAX_KISS_DIM)) begin
            res = KDIM_W'(MAX_KISS_DIM);
        end else begin
            res = KDIM_W'(v);
        end
        return res;
    endfunction

    function automatic logic [SDIM_W-1:0] clamp_src(input logic [CFG_SRC_W-1:0] v);
        logic [SDIM_W-1:0] res;
        if (v == '0) begin
            res = SDIM_W'(1);
        end else if (32'(v) > 32'(MAX_SOURCE_DIM)) begin
            res = SDIM_W'(MAX_SOURCE_DIM);
        end else begin
            res = SDIM_W'(v);
        end
        return res;
    endfunction

endpackage

// ===== design/rounded_rect_photo_scaler.sv =====
// A render goes from the command queue through back stages a to g into the output queue.
// Throughput: one item per cycle as credit allows; the 7-stage back pipeline never stalls.
// A load gives no result; loads and render reads share one port of the photo store.
// After reset and after every register write the block shows full while one radix-2
// divider forms draw sizes and the reciprocal; reset is synchronous.
module rounded_rect_photo_scaler (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  rrps_pkg::t_in_item                 i_item,
    output logic                               empty,
    input  logic                               pop,
    output rrps_pkg::t_out_item                o_result,
    input  logic                               i_cfg_we,
    input  logic [rrps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rrps_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import rrps_pkg::*;

    t_derived drv;
    t_cmd     cmd;
    logic     busy, cmd_vld, cmd_pop;

    // geometry and configuration
    rrps_setup u_setup (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_drv       (drv),
        .o_busy      (busy)
    );

    // accept and classify
    rrps_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_item    (i_item),
        .i_busy    (busy),
        .o_full    (full),
        .o_cmd     (cmd),
        .o_cmd_vld (cmd_vld),
        .i_cmd_pop (cmd_pop)
    );

    // render pipeline and photo store
    rrps_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_drv     (drv),
        .i_cmd     (cmd),
        .i_cmd_vld (cmd_vld),
        .o_cmd_pop (cmd_pop),
        .o_result  (o_result),
        .o_empty   (empty),
        .i_pop     (pop)
    );

endmodule

// ===== design/rrps_setup.sv =====
// configuration registers and geometry sequencer of the scaler
// depends on rrps_pkg and assert_macros.svh; one shared radix-2 divider
`include "assert_macros.svh"
module rrps_setup (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rrps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rrps_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output rrps_pkg::t_derived                 o_drv,
    output logic                               o_busy
);
    import rrps_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE = 10'b0000000001,
        ST_CMP  = 10'b0000000010,
        ST_SEL  = 10'b0000000100,
        ST_LW   = 10'b0000001000,
        ST_DW   = 10'b0000010000,
        ST_LH   = 10'b0000100000,
        ST_DH   = 10'b0001000000,
        ST_LM   = 10'b0010000000,
        ST_DM   = 10'b0100000000,
        ST_FIN  = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    logic [CFG_KISS_W-1:0] r_kw_cfg, r_kh_cfg;
    logic [CFG_RAD_W-1:0]  r_rad;
    logic [CFG_SRC_W-1:0]  r_sw_cfg, r_sh_cfg;
    logic                  r_crop;

    logic [KDIM_W-1:0] kw, kh;
    logic [SDIM_W-1:0] sw, sh;

    logic [PM_W-1:0]      r_pa, r_pb;
    logic [DSR_W-1:0]     r_num;
    logic [SDIM_W-1:0]    r_den;
    logic [DIV_W-1:0]     r_dvd, n_dvd;
    logic [DSR_W-1:0]     r_rem, n_rem, r_dsr;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DSR_W:0]       trial;
    logic                 ge, div_last, pick;
    logic [DRAW_W-1:0]    r_draw_w, r_draw_h;
    logic [RECIP_W-1:0]   r_recip;
    logic [R2_W-1:0]      r_r2;
    logic signed [OFF_W-1:0] r_off_x, r_off_y;
    logic [DIV_W-1:0]     dvd_w, dvd_h;

    // centering offset, truncated toward zero
    function automatic logic signed [OFF_W-1:0] center_off(
        input logic [KDIM_W-1:0] k, input logic [DRAW_W-1:0] d);
        logic signed [OFF_W-1:0] diff;
        diff = OFF_W'(k) - OFF_W'(d);
        return signed'(diff + OFF_W'(diff[OFF_W-1])) >>> 1;
    endfunction

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kw_cfg <= CFG_KISS_W'(1);
            r_kh_cfg <= CFG_KISS_W'(1);
            r_rad    <= '0;
            r_sw_cfg <= CFG_SRC_W'(1);
            r_sh_cfg <= CFG_SRC_W'(1);
            r_crop   <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_KISS_W: r_kw_cfg <= i_cfg_data[CFG_KISS_W-1:0];
                REG_KISS_H: r_kh_cfg <= i_cfg_data[CFG_KISS_W-1:0];
                REG_RADIUS: r_rad    <= i_cfg_data[CFG_RAD_W-1:0];
                REG_SRC_W:  r_sw_cfg <= i_cfg_data[CFG_SRC_W-1:0];
                REG_SRC_H:  r_sh_cfg <= i_cfg_data[CFG_SRC_W-1:0];
                REG_CROP:   r_crop   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // clamped dimensions
    assign kw = clamp_kiss(r_kw_cfg);
    assign kh = clamp_kiss(r_kh_cfg);
    assign sw = clamp_src(r_sw_cfg);
    assign sh = clamp_src(r_sh_cfg);

    // ratio choice and divider step
    assign pick     = r_crop ? (r_pa > r_pb) : (r_pa < r_pb);
    assign trial    = {r_rem, r_dvd[DIV_W-1]};
    assign ge       = trial >= {1'b0, r_dsr};
    assign n_rem    = ge ? DSR_W'(trial - {1'b0, r_dsr}) : DSR_W'(trial);
    assign n_dvd    = {r_dvd[DIV_W-2:0], ge};
    assign div_last = r_cnt == DIV_CNT_W'(DIV_W - 1);
    assign dvd_w    = ((DIV_W'(sw) * DIV_W'(r_num)) << 1) + DIV_W'(r_den);
    assign dvd_h    = ((DIV_W'(sh) * DIV_W'(r_num)) << 1) + DIV_W'(r_den);

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: n_state = ST_IDLE;
            ST_CMP:  n_state = ST_SEL;
            ST_SEL:  n_state = ST_LW;
            ST_LW:   n_state = ST_DW;
            ST_DW:   n_state = div_last ? ST_LH : ST_DW;
            ST_LH:   n_state = ST_DH;
            ST_DH:   n_state = div_last ? ST_LM : ST_DH;
            ST_LM:   n_state = ST_DM;
            ST_DM:   n_state = div_last ? ST_FIN : ST_DM;
            ST_FIN:  n_state = ST_IDLE;
            default: n_state = ST_CMP;
        endcase
        if (i_cfg_we) begin
            n_state = ST_CMP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CMP;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_CMP: begin
                r_pa <= PM_W'(kw) * PM_W'(sh);
                r_pb <= PM_W'(kh) * PM_W'(sw);
            end
            ST_SEL: begin
                r_num <= pick ? DSR_W'(kw) : DSR_W'(kh);
                r_den <= pick ? sw : sh;
            end
            ST_LW: begin
                r_dvd <= dvd_w;
                r_dsr <= DSR_W'(r_den) << 1;
                r_rem <= '0;
                r_cnt <= '0;
            end
            ST_LH: begin
                r_draw_w <= DRAW_W'(r_dvd);
                r_dvd    <= dvd_h;
                r_rem    <= '0;
                r_cnt    <= '0;
            end
            ST_LM: begin
                r_draw_h <= DRAW_W'(r_dvd);
                r_dvd    <= DIV_W'(1) << PROD_W;
                r_dsr    <= r_num;
                r_rem    <= '0;
                r_cnt    <= '0;
            end
            ST_DW, ST_DH, ST_DM: begin
                r_dvd <= n_dvd;
                r_rem <= n_rem;
                r_cnt <= r_cnt + DIV_CNT_W'(1);
            end
            ST_FIN: begin
                r_recip <= r_dvd;
                r_off_x <= center_off(kw, r_draw_w);
                r_off_y <= center_off(kh, r_draw_h);
                r_r2    <= R2_W'(r_rad) * R2_W'(r_rad);
            end
            default: ;
        endcase
    end

    // derived geometry
    always_comb begin
        o_drv.kw     = kw;
        o_drv.kh     = kh;
        o_drv.sw     = sw;
        o_drv.sh     = sh;
        o_drv.r      = r_rad;
        o_drv.r2     = r_r2;
        o_drv.num    = r_num;
        o_drv.den    = r_den;
        o_drv.recip  = r_recip;
        o_drv.draw_w = r_draw_w;
        o_drv.draw_h = r_draw_h;
        o_drv.off_x  = r_off_x;
        o_drv.off_y  = r_off_y;
    end

    assign o_busy = r_state != ST_IDLE;

    `RRPS_ASSERT(a_busy_after_cfg, i_clk, i_rst_n, i_cfg_we |=> o_busy)
    `RRPS_ASSERT(a_div_starts_clear, i_clk, i_rst_n, (r_state == ST_LW) |=> (r_cnt == '0))

endmodule

// ===== design/rrps_front.sv =====
// front end: accepts items, classifies them and queues commands
// depends on rrps_pkg and assert_macros.svh
`include "assert_macros.svh"
module rrps_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  rrps_pkg::t_in_item  i_item,
    input  logic                i_busy,
    output logic                o_full,
    output rrps_pkg::t_cmd      o_cmd,
    output logic                o_cmd_vld,
    input  logic                i_cmd_pop
);
    import rrps_pkg::*;

    t_cmd                 r_q [CQ_DEPTH];
    t_cmd                 cmd;
    logic [CQ_PTR_W-1:0]  r_wp, r_rp;
    logic [CQ_CNT_W-1:0]  r_cnt;
    logic                 wr, rd;

    // classify the incoming item
    always_comb begin
        cmd.is_render = i_item.opcode == OP_RENDER;
        cmd.ld_ok     = (i_item.opcode == OP_LOAD)
                        && (32'(i_item.source_address) < 32'(STORE_DEPTH));
        cmd.addr      = ADDR_W'(i_item.source_address);
        cmd.color     = i_item.source_color;
        cmd.dest_x    = i_item.dest_x;
        cmd.dest_y    = i_item.dest_y;
    end

    assign o_full    = i_busy || (r_cnt == CQ_CNT_W'(CQ_DEPTH));
    assign wr        = i_push && !o_full;
    assign o_cmd_vld = r_cnt != '0;
    assign rd        = i_cmd_pop && o_cmd_vld;
    assign o_cmd     = r_q[r_rp];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= cmd;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + CQ_PTR_W'(1);
            end
            if (rd) begin
                r_rp <= r_rp + CQ_PTR_W'(1);
            end
            case ({wr, rd})
                2'b10:   r_cnt <= r_cnt + CQ_CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CQ_CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    `RRPS_NEVER(a_cq_underflow, i_clk, i_rst_n, i_cmd_pop && (r_cnt == '0))
    `RRPS_NEVER(a_cq_push_busy, i_clk, i_rst_n, wr && i_busy)

endmodule

// ===== design/rrps_back.sv =====
// back end: mask test, scaling pipeline, photo store and result queue
// depends on rrps_pkg and assert_macros.svh
`include "assert_macros.svh"
module rrps_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rrps_pkg::t_derived  i_drv,
    input  rrps_pkg::t_cmd      i_cmd,
    input  logic                i_cmd_vld,
    output logic                o_cmd_pop,
    output rrps_pkg::t_out_item o_result,
    output logic                o_empty,
    input  logic                i_pop
);
    import rrps_pkg::*;

    typedef struct packed {
        logic                vld;
        logic                is_render;
        logic                ld_ok;
        logic [COLOR_W-1:0]  color;
        logic [ADDR_W-1:0]   idx;
        logic                inrect;
        logic                rzero;
        logic                has_dx;
        logic                has_dy;
        logic [RAD_W-1:0]    dx;
        logic [RAD_W-1:0]    dy;
        logic [SQ_W-1:0]     dx2;
        logic [SQ_W-1:0]     dy2;
        logic                masked;
        logic                in_draw;
        logic [POS_W-2:0]    pxu;
        logic [POS_W-2:0]    pyu;
        logic [PROD_W-1:0]   ax;
        logic [PROD_W-1:0]   ay;
        logic [PROD_W-1:0]   qx;
        logic [PROD_W-1:0]   qy;
        logic [REM_W-1:0]    prx;
        logic [REM_W-1:0]    pry;
        logic                sx_ok;
        logic                sy_ok;
        logic [SDIM_W-1:0]   sx;
        logic [SDIM_W-1:0]   sy;
        logic                src_ok;
    } t_bk;

    t_bk r_sa, r_sb, r_sc, r_sd, r_se, r_sf, r_sg;
    t_bk n_sa, n_sb, n_sc, n_sd, n_se, n_sf;

    logic [COLOR_W-1:0] r_mem [STORE_DEPTH];
    logic [COLOR_W-1:0] r_rd;

    t_out_item          r_oq [OUT_DEPTH];
    t_out_item          res;
    logic [OPTR_W-1:0]  r_owp, r_orp;
    logic [OCNT_W-1:0]  r_ocnt;
    logic               oq_push, oq_pop, pull;
    logic [CRED_W-1:0]  inflight;

    logic signed [MASK_W-1:0] xs, ys, rs, ws, hs, dxw, dyw;
    logic                     lo_x, hi_x, lo_y, hi_y;
    logic signed [POS_W-1:0]  pxs, pys;
    logic [MUL_W-1:0]         mx, my;
    logic [NP_W-1:0]          nx, ny;
    logic [REM_W-1:0]         rx, ry;
    logic [PROD_W-1:0]        qxf, qyf;
    logic [IX_W-1:0]          lin;

    // credit check: every stage and queued result holds a result slot
    assign inflight  = CRED_W'($countones({r_sa.vld, r_sb.vld, r_sc.vld, r_sd.vld,
                                           r_se.vld, r_sf.vld, r_sg.vld}));
    assign pull      = i_cmd_vld && ((CRED_W'(r_ocnt) + inflight) < CRED_W'(OUT_DEPTH));
    assign o_cmd_pop = pull;

    // stage a: rectangle, corner zones and destination position
    always_comb begin
        n_sa           = '0;
        n_sa.vld       = pull;
        n_sa.is_render = i_cmd.is_render;
        n_sa.ld_ok     = i_cmd.ld_ok;
        n_sa.color     = i_cmd.color;
        n_sa.idx       = i_cmd.addr;
        xs   = MASK_W'(i_cmd.dest_x);
        ys   = MASK_W'(i_cmd.dest_y);
        rs   = MASK_W'(i_drv.r);
        ws   = MASK_W'(i_drv.kw);
        hs   = MASK_W'(i_drv.kh);
        lo_x = xs < rs;
        hi_x = xs >= (ws - rs);
        lo_y = ys < rs;
        hi_y = ys >= (hs - rs);
        dxw  = lo_x ? (rs - MASK_W'(1) - xs) : (xs - (ws - rs));
        dyw  = lo_y ? (rs - MASK_W'(1) - ys) : (ys - (hs - rs));
        n_sa.inrect = (xs < ws) && (ys < hs);
        n_sa.rzero  = i_drv.r == '0;
        n_sa.has_dx = lo_x || hi_x;
        n_sa.has_dy = lo_y || hi_y;
        n_sa.dx     = RAD_W'(dxw);
        n_sa.dy     = RAD_W'(dyw);
        pxs  = POS_W'(i_cmd.dest_x) - POS_W'(i_drv.off_x);
        pys  = POS_W'(i_cmd.dest_y) - POS_W'(i_drv.off_y);
        n_sa.in_draw = !pxs[POS_W-1] && (pxs < POS_W'(i_drv.draw_w))
                       && !pys[POS_W-1] && (pys < POS_W'(i_drv.draw_h));
        n_sa.pxu = pxs[POS_W-2:0];
        n_sa.pyu = pys[POS_W-2:0];
    end

    // stage b: corner squares and scaled numerators
    always_comb begin
        n_sb     = r_sa;
        n_sb.dx2 = SQ_W'(r_sa.dx) * SQ_W'(r_sa.dx);
        n_sb.dy2 = SQ_W'(r_sa.dy) * SQ_W'(r_sa.dy);
        n_sb.ax  = PROD_W'(r_sa.pxu) * PROD_W'(i_drv.den);
        n_sb.ay  = PROD_W'(r_sa.pyu) * PROD_W'(i_drv.den);
    end

    // stage c: mask decision and reciprocal quotient estimate
    always_comb begin
        n_sc = r_sb;
        n_sc.masked = r_sb.inrect && (r_sb.rzero || !r_sb.has_dx || !r_sb.has_dy
                      || ((SQ_W+1)'(r_sb.dx2) + (SQ_W+1)'(r_sb.dy2)
                          <= (SQ_W+1)'(i_drv.r2)));
        mx = MUL_W'(r_sb.ax) * MUL_W'(i_drv.recip);
        my = MUL_W'(r_sb.ay) * MUL_W'(i_drv.recip);
        n_sc.qx = mx[PROD_W +: PROD_W];
        n_sc.qy = my[PROD_W +: PROD_W];
    end

    // stage d: estimate times divisor, low bits only
    always_comb begin
        n_sd = r_sc;
        nx = NP_W'(r_sc.qx) * NP_W'(i_drv.num);
        ny = NP_W'(r_sc.qy) * NP_W'(i_drv.num);
        n_sd.prx = nx[REM_W-1:0];
        n_sd.pry = ny[REM_W-1:0];
    end

    // stage e: one-step correction and source range check
    always_comb begin
        n_se  = r_sd;
        rx    = r_sd.ax[REM_W-1:0] - r_sd.prx;
        ry    = r_sd.ay[REM_W-1:0] - r_sd.pry;
        qxf   = r_sd.qx + PROD_W'(rx >= REM_W'(i_drv.num));
        qyf   = r_sd.qy + PROD_W'(ry >= REM_W'(i_drv.num));
        n_se.sx_ok = qxf < PROD_W'(i_drv.sw);
        n_se.sy_ok = qyf < PROD_W'(i_drv.sh);
        n_se.sx    = SDIM_W'(qxf);
        n_se.sy    = SDIM_W'(qyf);
    end

    // stage f: store address of the source pixel
    always_comb begin
        n_sf = r_se;
        lin  = IX_W'(r_se.sy) * IX_W'(i_drv.sw) + IX_W'(r_se.sx);
        n_sf.src_ok = r_se.masked && r_se.in_draw && r_se.sx_ok && r_se.sy_ok;
        if (r_se.is_render) begin
            n_sf.idx = ADDR_W'(lin);
        end
    end

    // pipeline registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sa <= '0;
            r_sb <= '0;
            r_sc <= '0;
            r_sd <= '0;
            r_se <= '0;
            r_sf <= '0;
            r_sg <= '0;
        end else begin
            r_sa <= n_sa;
            r_sb <= n_sb;
            r_sc <= n_sc;
            r_sd <= n_sd;
            r_se <= n_se;
            r_sf <= n_sf;
            r_sg <= r_sf;
        end
    end

    // photo store: loads and render reads meet in the same stage
    always_ff @(posedge i_clk) begin
        if (r_sf.vld && !r_sf.is_render && r_sf.ld_ok) begin
            r_mem[r_sf.idx] <= r_sf.color;
        end
        if (r_sf.vld && r_sf.is_render) begin
            r_rd <= r_mem[r_sf.idx];
        end
    end

    // result composition
    always_comb begin
        res.written    = r_sg.masked;
        res.from_photo = r_sg.masked && r_sg.src_ok;
        if (!r_sg.masked) begin
            res.pixel_color = '0;
        end else if (r_sg.src_ok) begin
            res.pixel_color = r_rd;
        end else begin
            res.pixel_color = WHITE;
        end
    end

    assign oq_push  = r_sg.vld && r_sg.is_render;
    assign o_empty  = r_ocnt == '0;
    assign oq_pop   = i_pop && !o_empty;
    assign o_result = r_oq[r_orp];

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (oq_push) begin
            r_oq[r_owp] <= res;
        end
    end

    // result queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= '0;
            r_orp  <= '0;
            r_ocnt <= '0;
        end else begin
            if (oq_push) begin
                r_owp <= r_owp + OPTR_W'(1);
            end
            if (oq_pop) begin
                r_orp <= r_orp + OPTR_W'(1);
            end
            case ({oq_push, oq_pop})
                2'b10:   r_ocnt <= r_ocnt + OCNT_W'(1);
                2'b01:   r_ocnt <= r_ocnt - OCNT_W'(1);
                default: r_ocnt <= r_ocnt;
            endcase
        end
    end

    `RRPS_NEVER(a_oq_overflow, i_clk, i_rst_n, oq_push && !oq_pop && (r_ocnt == OCNT_W'(OUT_DEPTH)))
    `RRPS_ASSERT(a_unmasked_black, i_clk, i_rst_n, (!o_empty && !o_result.written) |-> (o_result.pixel_color == '0))

endmodule

// ===== bench/testbench.sv =====
// self-checking testbench of the rounded-rect photo scaler
// depends on rrps_pkg and the rounded_rect_photo_scaler design files
module testbench;
    import rrps_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    t_in_item    i_item = '0;
    logic        empty;
    logic        pop = 1'b0;
    t_out_item   o_result;
    logic        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // mirror of the block registers and photo store
    logic [11:0] kiss_w_reg, kiss_h_reg;
    logic [10:0] radius_reg;
    logic [8:0]  src_w_reg, src_h_reg;
    logic        crop_reg;
    logic [COLOR_W-1:0] photo [STORE_DEPTH];
    bit          stocked [STORE_DEPTH];

    t_out_item   pixel_queue [$];
    int          mismatches = 0;
    int          burst_left = 0;
    int          hold_cycles = 0;
    int          stall_mode = 0;
    int          mode_timer = 0;

    rounded_rect_photo_scaler dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_item(i_item),
        .empty(empty), .pop(pop), .o_result(o_result), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    function automatic longint clamp_size(longint v, longint maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    // expected pixel of a render; photo_idx is -1 when no store read happens
    function automatic t_out_item predict_pixel(t_in_item it, output int photo_idx);
        longint kw, kh, sw, sh, r, x, y, dx, dy, num, den;
        longint draw_w, draw_h, off_x, off_y, px, py, sx, sy;
        bit in_shape, pick_x;
        t_out_item res;
        kw = clamp_size(kiss_w_reg, MAX_KISS_DIM);
        kh = clamp_size(kiss_h_reg, MAX_KISS_DIM);
        sw = clamp_size(src_w_reg, MAX_SOURCE_DIM);
        sh = clamp_size(src_h_reg, MAX_SOURCE_DIM);
        r = radius_reg;
        x = it.dest_x;
        y = it.dest_y;
        photo_idx = -1;
        res = '0;
        // rounded-corner mask, left and top corners win
        dx = -1;
        dy = -1;
        in_shape = (x < kw) && (y < kh);
        if (in_shape && r > 0) begin
            if (x < r) dx = r - 1 - x;
            else if (x >= kw - r) dx = x - (kw - r);
            if (y < r) dy = r - 1 - y;
            else if (y >= kh - r) dy = y - (kh - r);
            if (dx >= 0 && dy >= 0) in_shape = (dx * dx + dy * dy <= r * r);
        end
        if (!in_shape) return res;
        // exact scale ratio
        pick_x = crop_reg ? (kw * sh > kh * sw) : (kw * sh < kh * sw);
        num = pick_x ? kw : kh;
        den = pick_x ? sw : sh;
        draw_w = (2 * sw * num + den) / (2 * den);
        draw_h = (2 * sh * num + den) / (2 * den);
        off_x = (kw - draw_w) / 2;
        off_y = (kh - draw_h) / 2;
        res.written = 1'b1;
        res.pixel_color = WHITE;
        px = x - off_x;
        py = y - off_y;
        if (px >= 0 && px < draw_w && py >= 0 && py < draw_h) begin
            sx = px * den / num;
            sy = py * den / num;
            if (sx < sw && sy < sh && sy * sw + sx < STORE_DEPTH) begin
                photo_idx = int'(sy * sw + sx);
                res.from_photo = 1'b1;
                res.pixel_color = photo[photo_idx];
            end
        end
        return res;
    endfunction

    // input transfers update the mirror, result transfers are checked
    always @(posedge i_clk) begin
        int idx;
        t_out_item want;
        if (push && !full) begin
            if (i_item.opcode == OP_LOAD) begin
                photo[i_item.source_address] <= i_item.source_color;
            end else begin
                pixel_queue.push_back(predict_pixel(i_item, idx));
            end
        end
        if (pop && !empty) begin
            if (pixel_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_result);
            end else begin
                want = pixel_queue.pop_front();
                if (want.written !== o_result.written || want.from_photo !== o_result.from_photo
                        || want.pixel_color !== o_result.pixel_color) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pixel mismatch: expected %p, got %p", want, o_result);
                end
            end
        end
    end

    // receiver stall pattern plus long hold-off
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            pop <= 1'b0;
        end else begin
            if (mode_timer == 0) begin
                stall_mode <= $urandom_range(0, 2);
                mode_timer <= $urandom_range(16, 96);
            end else begin
                mode_timer <= mode_timer - 1;
            end
            case (stall_mode)
                0: pop <= 1'b1;
                1: pop <= ($urandom_range(0, 1) == 1);
                default: pop <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // one input transfer, with bursts and random gaps
    task automatic push_raw(t_in_item it);
        push <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (it.opcode == OP_LOAD) stocked[it.source_address] = 1'b1;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            if ($urandom_range(0, 2) != 0) begin
                push <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    endtask

    // renders that read a never-loaded photo entry get a load first
    task automatic send_item(t_in_item it);
        int idx;
        t_out_item unused;
        t_in_item ld;
        if (it.opcode == OP_RENDER) begin
            unused = predict_pixel(it, idx);
            if (idx >= 0 && !stocked[idx]) begin
                ld = '0;
                ld.opcode = OP_LOAD;
                ld.source_address = idx[15:0];
                ld.source_color = COLOR_W'($urandom);
                push_raw(ld);
            end
        end
        push_raw(it);
    endtask

    task automatic send_render(int x, int y);
        t_in_item it;
        it = '0;
        it.opcode = OP_RENDER;
        it.dest_x = DEST_W'(x);
        it.dest_y = DEST_W'(y);
        send_item(it);
    endtask

    task automatic send_load(int addr, int color);
        t_in_item it;
        it = '0;
        it.opcode = OP_LOAD;
        it.source_address = SRC_ADDR_W'(addr);
        it.source_color = COLOR_W'(color);
        send_item(it);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        @(posedge i_clk);
        while (pixel_queue.size() != 0) @(posedge i_clk);
        repeat (15) @(posedge i_clk);
    endtask

    task automatic set_geometry(int kw, int kh, int rad, int sw, int sh, int crop);
        t_reg_idx idx;
        int vals [6];
        vals = '{kw, kh, rad, sw, sh, crop};
        wait_idle();
        for (int i = 0; i < 6; i++) begin
            idx = t_reg_idx'(i);
            i_cfg_we <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data <= CFG_DATA_W'(vals[i]);
            case (idx)
                REG_KISS_W: kiss_w_reg = 12'(vals[i]);
                REG_KISS_H: kiss_h_reg = 12'(vals[i]);
                REG_RADIUS: radius_reg = 11'(vals[i]);
                REG_SRC_W:  src_w_reg = 9'(vals[i]);
                REG_SRC_H:  src_h_reg = 9'(vals[i]);
                default:    crop_reg = vals[i][0];
            endcase
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic int kiss_w_now();
        return int'(clamp_size(kiss_w_reg, MAX_KISS_DIM));
    endfunction

    function automatic int kiss_h_now();
        return int'(clamp_size(kiss_h_reg, MAX_KISS_DIM));
    endfunction

    // reset values of the registers
    task automatic test_reset_defaults();
        send_render(0, 0);
        send_render(1, 0);
        send_render(2047, 2047);
    endtask

    // extremes, saturation, zero sizes, big radii, both scale modes
    task automatic test_directed();
        send_load(65535, 24'hFFFFFF);
        send_load(0, 24'h000000);
        set_geometry(2048, 2048, 1024, 256, 256, 1);
        send_render(0, 0);
        send_render(1024, 1024);
        send_render(2047, 2047);
        send_render(2047, 1024);
        set_geometry(4095, 0, 2047, 511, 0, 0);
        send_render(0, 0);
        send_render(2047, 0);
        set_geometry(40, 20, 0, 8, 8, 0);
        send_render(0, 0);
        send_render(20, 10);
        send_render(39, 19);
        set_geometry(40, 20, 0, 8, 8, 1);
        send_render(0, 0);
        send_render(39, 19);
        send_render(40, 5);
        set_geometry(30, 30, 25, 5, 7, 1);
        send_render(0, 0);
        send_render(15, 15);
        send_render(29, 0);
    endtask

    // random geometry phases with loads and renders
    task automatic test_random();
        int kw, kh, rad, sw, sh;
        for (int phase = 0; phase < 10; phase++) begin
            if ($urandom_range(0, 4) == 0) begin
                kw = $urandom_range(0, 4095);
                kh = $urandom_range(0, 4095);
                rad = $urandom_range(0, 4095);
                sw = $urandom_range(0, 4095);
                sh = $urandom_range(0, 4095);
            end else begin
                kw = $urandom_range(1, 64);
                kh = $urandom_range(1, 64);
                rad = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
                sw = $urandom_range(1, 16);
                sh = $urandom_range(1, 16);
            end
            set_geometry(kw, kh, rad, sw, sh, $urandom_range(0, 1));
            for (int n = 0; n < 60; n++) begin
                if ($urandom_range(0, 3) == 0)
                    send_load($urandom_range(0, 65535), $urandom_range(0, 24'hFFFFFF));
                else if ($urandom_range(0, 4) == 0)
                    send_render($urandom_range(0, 2047), $urandom_range(0, 2047));
                else
                    send_render($urandom_range(0, kiss_w_now() - 1),
                                $urandom_range(0, kiss_h_now() - 1));
            end
        end
    endtask

    // receiver holds off long enough for the block to fill and push back
    task automatic test_backpressure();
        set_geometry(16, 16, 4, 4, 4, 1);
        hold_cycles = 300;
        for (int n = 0; n < 60; n++)
            send_render($urandom_range(0, 15), $urandom_range(0, 15));
    endtask

    initial begin
        kiss_w_reg = 1;
        kiss_h_reg = 1;
        radius_reg = 0;
        src_w_reg = 1;
        src_h_reg = 1;
        crop_reg = 1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_directed();
        test_random();
        test_backpressure();
        wait_idle();
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
